### rtl/indexed_min_heap_decrease_key_core_macros.svh
// assertion macros for the indexed min-heap core
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IMHDK_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IMHDK_ASSERT_NORST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IMHDK_ASSERT(name, clk, rst_n, prop, msg)
`define IMHDK_ASSERT_NORST(name, clk, prop, msg)
`endif
`endif

### rtl/imhdk_pkg.sv
// shared types and constants for the indexed min-heap core
`default_nettype none
package imhdk_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned SlotBits    = $clog2(MaxElements);
  localparam int unsigned CountBits   = SlotBits + 1;
  localparam int unsigned IdBits      = 10;
  localparam int unsigned PrioBits    = 32;

  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [IdBits-1:0]    id_t;
  typedef logic [PrioBits-1:0]  prio_t;

  typedef enum logic [2:0] {
    KIND_PUSH     = 3'd0,
    KIND_DECREASE = 3'd1,
    KIND_POP      = 3'd2,
    KIND_CLEAR    = 3'd3,
    KIND_QUERY    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_RAISED    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PRE,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMPL,
    S_DN_CMPR,
    S_RPT,
    S_RPT2,
    S_RPT3
  } state_e;

  typedef struct packed {
    id_t   elem;
    prio_t prio;
  } heap_entry_t;

  typedef struct packed {
    logic        en;
    slot_t       addr;
    heap_entry_t data;
  } heap_wr_t;

endpackage
`default_nettype wire

### rtl/indexed_min_heap_decrease_key_core.sv
// a transaction runs S_PRE, S_DECIDE, the sift, then S_RPT, S_RPT2 and S_RPT3; sift-up steps
// S_UP_RD and S_UP_CMP per level climbed, sift-down S_DN_RD, S_DN_CMPL, S_DN_CMPR per level
// one transaction in flight; the next is taken in S_IDLE, entered as the result is registered
// the sift pace is set by the single shared priority comparator and the registered ram reads
// after reset S_INIT clears all 1024 entries of the id-to-slot table before the first transaction
`default_nettype none
`include "indexed_min_heap_decrease_key_core_macros.svh"
module indexed_min_heap_decrease_key_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [9:0]  element_id_i,
  input  logic [31:0] new_priority_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [9:0]  top_element_o,
  output logic [31:0] top_priority_o,
  output logic        is_empty_o,
  output logic        element_present_o,
  output logic [31:0] element_priority_o,
  output logic [10:0] entry_count_o
);

  imhdk_pkg::state_e      state_q, state_d;
  imhdk_pkg::kind_e       kind_q, kind_d;
  imhdk_pkg::id_t         id_q, id_d;
  imhdk_pkg::prio_t       prio_q, prio_d;
  imhdk_pkg::count_t      count_q, count_d;
  imhdk_pkg::slot_t       hole_q, hole_d;
  imhdk_pkg::heap_entry_t mov_q, mov_d;
  imhdk_pkg::heap_entry_t best_q, best_d;
  imhdk_pkg::slot_t       best_slot_q, best_slot_d;
  logic                   best_take_q, best_take_d;
  imhdk_pkg::status_e     status_q, status_d;
  imhdk_pkg::slot_t       init_cnt_q, init_cnt_d;
  logic                   out_valid_q, out_valid_d;

  imhdk_pkg::status_e     out_status_q;
  imhdk_pkg::id_t         out_top_elem_q;
  imhdk_pkg::prio_t       out_top_prio_q;
  logic                   out_empty_q;
  logic                   out_present_q;
  imhdk_pkg::prio_t       out_elem_prio_q;
  imhdk_pkg::count_t      out_count_q;
  logic                   out_load;

  imhdk_pkg::heap_wr_t    heap_wr;
  imhdk_pkg::slot_t       rd_addr_a, rd_addr_b;
  imhdk_pkg::heap_entry_t rd_a, rd_b;

  imhdk_pkg::slot_t       es_mem_q [imhdk_pkg::MaxElements];
  imhdk_pkg::slot_t       es_rd_q;
  imhdk_pkg::id_t         es_raddr;
  logic                   es_we;
  imhdk_pkg::id_t         es_waddr;
  imhdk_pkg::slot_t       es_wdata;

  imhdk_pkg::prio_t       cmp_x, cmp_y;
  logic                   cmp_lt;
  imhdk_pkg::slot_t       hole_m1, parent;
  imhdk_pkg::count_t      left, right;
  logic                   slot_live;

  imhdk_heap_ram u_heap_ram (
    .clk_i      (clk_i),
    .wr_i       (heap_wr),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .rd_data_a_o(rd_a),
    .rd_data_b_o(rd_b)
  );

  // id to heap slot table
  assign es_raddr = (state_q == imhdk_pkg::S_IDLE) ? element_id_i : id_q;

  always_ff @(posedge clk_i) begin
    if (es_we) begin
      es_mem_q[es_waddr] <= es_wdata;
    end
    es_rd_q <= es_mem_q[es_raddr];
  end

  assign hole_m1   = hole_q - imhdk_pkg::slot_t'(1);
  assign parent    = hole_m1 >> 1;
  assign left      = {hole_q, 1'b1};
  assign right     = left + imhdk_pkg::count_t'(1);
  // an id is present when its slot is live and that slot names it back
  assign slot_live = ({1'b0, es_rd_q} < count_q) && (rd_a.elem == id_q);

  // shared priority comparator
  always_comb begin
    cmp_x = rd_a.prio;
    cmp_y = prio_q;
    unique case (state_q)
      imhdk_pkg::S_UP_CMP: begin
        cmp_x = mov_q.prio;
        cmp_y = rd_a.prio;
      end
      imhdk_pkg::S_DN_CMPL: begin
        cmp_x = rd_a.prio;
        cmp_y = mov_q.prio;
      end
      imhdk_pkg::S_DN_CMPR: begin
        cmp_x = rd_b.prio;
        cmp_y = best_q.prio;
      end
      default: begin
        cmp_x = rd_a.prio;
        cmp_y = prio_q;
      end
    endcase
  end

  assign cmp_lt = cmp_x < cmp_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imhdk_pkg::S_INIT;
      count_q     <= '0;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    id_q        <= id_d;
    prio_q      <= prio_d;
    hole_q      <= hole_d;
    mov_q       <= mov_d;
    best_q      <= best_d;
    best_slot_q <= best_slot_d;
    best_take_q <= best_take_d;
    status_q    <= status_d;
    if (out_load) begin
      out_status_q    <= status_q;
      out_count_q     <= count_q;
      out_empty_q     <= (count_q == '0);
      out_top_elem_q  <= (count_q != '0) ? rd_b.elem : '0;
      out_top_prio_q  <= (count_q != '0) ? rd_b.prio : '0;
      out_present_q   <= slot_live;
      out_elem_prio_q <= slot_live ? rd_a.prio : '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    id_d        = id_q;
    prio_d      = prio_q;
    count_d     = count_q;
    hole_d      = hole_q;
    mov_d       = mov_q;
    best_d      = best_q;
    best_slot_d = best_slot_q;
    best_take_d = best_take_q;
    status_d    = status_q;
    init_cnt_d  = init_cnt_q;
    heap_wr     = '0;
    es_we       = 1'b0;
    es_waddr    = id_q;
    es_wdata    = '0;
    rd_addr_a   = es_rd_q;
    rd_addr_b   = '0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      imhdk_pkg::S_INIT: begin
        es_we      = 1'b1;
        es_waddr   = init_cnt_q;
        es_wdata   = '0;
        init_cnt_d = init_cnt_q + imhdk_pkg::slot_t'(1);
        if (init_cnt_q == imhdk_pkg::slot_t'(imhdk_pkg::MaxElements - 1)) begin
          state_d = imhdk_pkg::S_IDLE;
        end
      end
      imhdk_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = imhdk_pkg::kind_e'(kind_i);
          id_d    = element_id_i;
          prio_d  = new_priority_i;
          state_d = imhdk_pkg::S_PRE;
        end
      end
      imhdk_pkg::S_PRE: begin
        rd_addr_a = es_rd_q;
        rd_addr_b = imhdk_pkg::slot_t'(count_q - imhdk_pkg::count_t'(1));
        state_d   = imhdk_pkg::S_DECIDE;
      end
      imhdk_pkg::S_DECIDE: begin
        status_d = imhdk_pkg::ST_OK;
        state_d  = imhdk_pkg::S_RPT;
        unique case (kind_q)
          imhdk_pkg::KIND_PUSH: begin
            if (slot_live) begin
              status_d = imhdk_pkg::ST_DUPLICATE;
            end else if (count_q != imhdk_pkg::count_t'(imhdk_pkg::MaxElements)) begin
              hole_d     = imhdk_pkg::slot_t'(count_q);
              mov_d.elem = id_q;
              mov_d.prio = prio_q;
              count_d    = count_q + imhdk_pkg::count_t'(1);
              state_d    = imhdk_pkg::S_UP_RD;
            end
          end
          imhdk_pkg::KIND_DECREASE: begin
            if (!slot_live) begin
              status_d = imhdk_pkg::ST_ABSENT;
            end else if (cmp_lt) begin
              status_d = imhdk_pkg::ST_RAISED;
            end else begin
              hole_d     = es_rd_q;
              mov_d.elem = id_q;
              mov_d.prio = prio_q;
              state_d    = imhdk_pkg::S_UP_RD;
            end
          end
          imhdk_pkg::KIND_POP: begin
            if (count_q == '0) begin
              status_d = imhdk_pkg::ST_EMPTY;
            end else begin
              count_d = count_q - imhdk_pkg::count_t'(1);
              if (count_q != imhdk_pkg::count_t'(1)) begin
                mov_d   = rd_b;
                hole_d  = '0;
                state_d = imhdk_pkg::S_DN_RD;
              end
            end
          end
          imhdk_pkg::KIND_CLEAR: begin
            count_d = '0;
          end
          default: begin
            status_d = imhdk_pkg::ST_OK;
          end
        endcase
      end
      imhdk_pkg::S_UP_RD: begin
        rd_addr_a = parent;
        if (hole_q == '0) begin
          heap_wr.en   = 1'b1;
          heap_wr.addr = hole_q;
          heap_wr.data = mov_q;
          es_we        = 1'b1;
          es_waddr     = mov_q.elem;
          es_wdata     = hole_q;
          state_d      = imhdk_pkg::S_RPT;
        end else begin
          state_d = imhdk_pkg::S_UP_CMP;
        end
      end
      imhdk_pkg::S_UP_CMP: begin
        rd_addr_a    = parent;
        heap_wr.en   = 1'b1;
        heap_wr.addr = hole_q;
        es_we        = 1'b1;
        es_wdata     = hole_q;
        if (cmp_lt) begin
          // parent strictly greater: it moves down into the hole
          heap_wr.data = rd_a;
          es_waddr     = rd_a.elem;
          hole_d       = parent;
          state_d      = imhdk_pkg::S_UP_RD;
        end else begin
          heap_wr.data = mov_q;
          es_waddr     = mov_q.elem;
          state_d      = imhdk_pkg::S_RPT;
        end
      end
      imhdk_pkg::S_DN_RD: begin
        rd_addr_a = imhdk_pkg::slot_t'(left);
        rd_addr_b = imhdk_pkg::slot_t'(right);
        if (left >= count_q) begin
          heap_wr.en   = 1'b1;
          heap_wr.addr = hole_q;
          heap_wr.data = mov_q;
          es_we        = 1'b1;
          es_waddr     = mov_q.elem;
          es_wdata     = hole_q;
          state_d      = imhdk_pkg::S_RPT;
        end else begin
          state_d = imhdk_pkg::S_DN_CMPL;
        end
      end
      imhdk_pkg::S_DN_CMPL: begin
        rd_addr_a = imhdk_pkg::slot_t'(left);
        rd_addr_b = imhdk_pkg::slot_t'(right);
        if (cmp_lt) begin
          best_take_d = 1'b1;
          best_slot_d = imhdk_pkg::slot_t'(left);
          best_d      = rd_a;
        end else begin
          best_take_d = 1'b0;
          best_slot_d = hole_q;
          best_d      = mov_q;
        end
        state_d = imhdk_pkg::S_DN_CMPR;
      end
      imhdk_pkg::S_DN_CMPR: begin
        rd_addr_a    = imhdk_pkg::slot_t'(left);
        rd_addr_b    = imhdk_pkg::slot_t'(right);
        heap_wr.en   = 1'b1;
        heap_wr.addr = hole_q;
        es_we        = 1'b1;
        es_wdata     = hole_q;
        // right child wins only when strictly smaller, so ties keep the left
        if ((right < count_q) && cmp_lt) begin
          heap_wr.data = rd_b;
          es_waddr     = rd_b.elem;
          hole_d       = imhdk_pkg::slot_t'(right);
          state_d      = imhdk_pkg::S_DN_RD;
        end else if (best_take_q) begin
          heap_wr.data = best_q;
          es_waddr     = best_q.elem;
          hole_d       = best_slot_q;
          state_d      = imhdk_pkg::S_DN_RD;
        end else begin
          heap_wr.data = mov_q;
          es_waddr     = mov_q.elem;
          state_d      = imhdk_pkg::S_RPT;
        end
      end
      imhdk_pkg::S_RPT: begin
        state_d = imhdk_pkg::S_RPT2;
      end
      imhdk_pkg::S_RPT2: begin
        rd_addr_a = es_rd_q;
        rd_addr_b = '0;
        state_d   = imhdk_pkg::S_RPT3;
      end
      imhdk_pkg::S_RPT3: begin
        rd_addr_a = es_rd_q;
        rd_addr_b = '0;
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = imhdk_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = imhdk_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready_o         = (state_q == imhdk_pkg::S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign top_element_o      = out_top_elem_q;
  assign top_priority_o     = out_top_prio_q;
  assign is_empty_o         = out_empty_q;
  assign element_present_o  = out_present_q;
  assign element_priority_o = out_elem_prio_q;
  assign entry_count_o      = out_count_q;

  `IMHDK_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "block took a transaction while busy")
  `IMHDK_ASSERT(a_up_reads_parent, clk_i, rst_ni, (state_q == imhdk_pkg::S_UP_RD && hole_q != '0) |=> (state_q == imhdk_pkg::S_UP_CMP), "sift-up skipped its compare")
  `IMHDK_ASSERT(a_count_step, clk_i, rst_ni, (count_q != $past(count_q)) |-> (count_q == $past(count_q) + imhdk_pkg::count_t'(1) || count_q == $past(count_q) - imhdk_pkg::count_t'(1) || count_q == '0), "entry count jumped")
  `IMHDK_ASSERT_NORST(a_write_in_heap, clk_i, heap_wr.en |-> ({1'b0, heap_wr.addr} < count_q), "heap write beyond the live entries")

endmodule
`default_nettype wire

### rtl/imhdk_heap_ram.sv
// heap slot storage: one write port and two registered read ports
`default_nettype none
module imhdk_heap_ram (
  input  logic                   clk_i,
  input  imhdk_pkg::heap_wr_t    wr_i,
  input  imhdk_pkg::slot_t       rd_addr_a_i,
  input  imhdk_pkg::slot_t       rd_addr_b_i,
  output imhdk_pkg::heap_entry_t rd_data_a_o,
  output imhdk_pkg::heap_entry_t rd_data_b_o
);

  imhdk_pkg::heap_entry_t mem_q [imhdk_pkg::MaxElements];
  imhdk_pkg::heap_entry_t rd_a_q;
  imhdk_pkg::heap_entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule
`default_nettype wire
